/* sv/assert_macros.svh */
// Assertion macros for the checker file.
// Standalone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define RMSNG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define RMSNG_NEVER(label, clk, rst, expr, msg) \
  `RMSNG_ASSERT(label, clk, rst, !(expr), msg)

`endif

/* sv/rmsng_pkg.sv */
// Package for the RMS noise gate: item types, config register set,
// register indexes and fixed-point constants. No dependencies.
package rmsng_pkg;

  localparam int SampleW = 16;
  localparam int MagW    = 17;
  localparam int CoeffW  = 24;
  localparam int PoleW   = 25;
  localparam int MulBW   = 20;
  localparam int ProdW   = PoleW + MulBW;
  localparam int AccW    = 64;
  localparam int MsW     = 40;
  localparam int SqW     = 39;
  localparam int GainW   = 32;
  localparam int TgtW    = 31;
  localparam int ThrW    = 31;
  localparam int RangeW  = 16;
  localparam int HoldW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 31;

  localparam logic [PoleW-1:0]  POLE_ONE  = PoleW'(1) << 24;
  localparam logic [AccW-1:0]   POLE_HALF = AccW'(1) << 23;
  localparam logic [AccW-1:0]   OUT_HALF  = AccW'(1) << 29;
  localparam logic [GainW-1:0]  GAIN_ONE  = GainW'(1) << 30;
  localparam logic [TgtW-1:0]   TGT_ONE   = TgtW'(1) << 30;
  localparam logic [RangeW-1:0] RANGE_MAX = RangeW'(32768);

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ATTACK    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RMS       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HOLD      = 3'd5;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      block_end_out;
  } out_item_t;

  typedef struct packed {
    logic [ThrW-1:0]   threshold_power;
    logic [RangeW-1:0] range_gain;
    logic [CoeffW-1:0] attack_coeff;
    logic [CoeffW-1:0] release_coeff;
    logic [CoeffW-1:0] rms_coeff;
    logic [HoldW-1:0]  hold_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold_power: ThrW'(107374),
    range_gain:      RangeW'(3),
    attack_coeff:    CoeffW'(16431300),
    release_coeff:   CoeffW'(16773721),
    rms_coeff:       CoeffW'(16707456),
    hold_length:     HoldW'(2400)
  };

  // One multiply-accumulate request to the shared unit.
  typedef struct packed {
    logic valid;
    logic clear;
    logic shift;
  } mac_op_t;

endpackage

/* sv/rms_noise_gate_top.sv */
// Noise gate with mean-square detector, hold, attack and release: one
// sample item in, one gated sample item out. All products run through one
// 25x20 multiply-accumulate unit in sequence: one for the squared sample,
// four each for the envelope and gain one-pole filters (40- and 32-bit state
// split at bit 20), two for the output scaling, plus the pipeline drain
// and compare/update steps. The input is stalled while an item is in work;
// a finished result waits in the output register while the next item is
// taken. Config writes should be made only while idle.
// Depends on rmsng_pkg, rmsng_cfg, rmsng_mac, rmsng_ctrl.
module rms_noise_gate_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          audio_valid,
  output logic                          audio_stall,
  input  rmsng_pkg::in_item_t           audio_item,
  output logic                          gated_valid,
  input  logic                          gated_stall,
  output rmsng_pkg::out_item_t          gated_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmsng_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rmsng_pkg::CfgDatW-1:0] cfg_data
);

  rmsng_pkg::cfg_t              regs;
  rmsng_pkg::mac_op_t           mac_op;
  logic [rmsng_pkg::PoleW-1:0]  mac_a;
  logic [rmsng_pkg::MulBW-1:0]  mac_b;
  logic [rmsng_pkg::AccW-1:0]   acc;

  rmsng_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  rmsng_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  rmsng_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .audio_valid (audio_valid),
    .audio_stall (audio_stall),
    .audio_item  (audio_item),
    .gated_valid (gated_valid),
    .gated_stall (gated_stall),
    .gated_item  (gated_item),
    .mac_op      (mac_op),
    .mac_a       (mac_a),
    .mac_b       (mac_b),
    .acc         (acc)
  );

endmodule

/* sv/rmsng_cfg.sv */
// Configuration register file for the RMS noise gate.
// Depends on rmsng_pkg.
module rmsng_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmsng_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rmsng_pkg::CfgDatW-1:0] cfg_data,
  output rmsng_pkg::cfg_t               regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= rmsng_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmsng_pkg::REG_THRESHOLD: begin
          regs.threshold_power <= cfg_data[rmsng_pkg::ThrW-1:0];
        end
        rmsng_pkg::REG_RANGE: begin
          regs.range_gain <= cfg_data[rmsng_pkg::RangeW-1:0];
        end
        rmsng_pkg::REG_ATTACK: begin
          regs.attack_coeff <= cfg_data[rmsng_pkg::CoeffW-1:0];
        end
        rmsng_pkg::REG_RELEASE: begin
          regs.release_coeff <= cfg_data[rmsng_pkg::CoeffW-1:0];
        end
        rmsng_pkg::REG_RMS: begin
          regs.rms_coeff <= cfg_data[rmsng_pkg::CoeffW-1:0];
        end
        rmsng_pkg::REG_HOLD: begin
          regs.hold_length <= cfg_data[rmsng_pkg::HoldW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/rmsng_mac.sv */
// Shared multiply-accumulate unit: registered 25x20 product, then
// accumulate with optional 20-bit left shift. Depends on rmsng_pkg.
module rmsng_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  rmsng_pkg::mac_op_t          op,
  input  logic [rmsng_pkg::PoleW-1:0] a,
  input  logic [rmsng_pkg::MulBW-1:0] b,
  output logic [rmsng_pkg::AccW-1:0]  acc
);

  rmsng_pkg::mac_op_t               op_q;
  logic [rmsng_pkg::ProdW-1:0]      prod;
  logic [rmsng_pkg::AccW-1:0]       prod_ext;
  logic [rmsng_pkg::AccW-1:0]       acc_next;

  assign prod_ext = op_q.shift ? (rmsng_pkg::AccW'(prod) << rmsng_pkg::MulBW)
                               : rmsng_pkg::AccW'(prod);
  assign acc_next = (op_q.clear ? '0 : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (op_q.valid) begin
      acc <= acc_next;
    end
  end

endmodule

/* sv/rmsng_ctrl.sv */
// Sequencer and state for the RMS noise gate: envelope, hold counter,
// gain smoothing and output scaling on the shared MAC. Depends on rmsng_pkg.
module rmsng_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  rmsng_pkg::cfg_t             regs,
  input  logic                        audio_valid,
  output logic                        audio_stall,
  input  rmsng_pkg::in_item_t         audio_item,
  output logic                        gated_valid,
  input  logic                        gated_stall,
  output rmsng_pkg::out_item_t        gated_item,
  output rmsng_pkg::mac_op_t          mac_op,
  output logic [rmsng_pkg::PoleW-1:0] mac_a,
  output logic [rmsng_pkg::MulBW-1:0] mac_b,
  input  logic [rmsng_pkg::AccW-1:0]  acc
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_MS0, S_MS1, S_MS2, S_MS3, S_MSW, S_MSR, S_THR, S_TGT,
    S_G0, S_G1, S_G2, S_G3, S_GW, S_GR, S_O0, S_O1, S_OW, S_OR
  } state_t;

  state_t                               state;
  logic [rmsng_pkg::MsW-1:0]            mean_square;
  logic [rmsng_pkg::GainW-1:0]          gate_gain;
  logic [rmsng_pkg::HoldW-1:0]          hold_count;
  logic [rmsng_pkg::MagW-1:0]           mag;
  logic                                 neg;
  logic                                 blk;
  logic [rmsng_pkg::SqW-1:0]            sq;
  logic [rmsng_pkg::TgtW-1:0]           target;
  logic [rmsng_pkg::CoeffW-1:0]         pole;
  logic                                 gate_open;

  logic [rmsng_pkg::MagW-1:0]           mag_in;
  logic [rmsng_pkg::PoleW-1:0]          rms_inv;
  logic [rmsng_pkg::PoleW-1:0]          pole_inv;
  logic [rmsng_pkg::AccW-1:0]           pole_sum;
  logic [rmsng_pkg::AccW-1:0]           out_sum;
  logic [rmsng_pkg::GainW-1:0]          gain_raw;
  logic [rmsng_pkg::GainW-1:0]          gain_next;
  logic                                 above;
  logic [rmsng_pkg::HoldW-1:0]          hold_next;
  logic [rmsng_pkg::RangeW-1:0]         floor_gain;
  logic [rmsng_pkg::TgtW-1:0]           target_next;
  logic [rmsng_pkg::MagW-1:0]           omag;
  logic [rmsng_pkg::MagW-1:0]           omag_neg;
  logic                                 out_load;

  assign audio_stall = (state != S_IDLE);

  assign mag_in   = audio_item.sample_in[rmsng_pkg::SampleW-1]
                  ? rmsng_pkg::MagW'(0) - {1'b1, audio_item.sample_in}
                  : {1'b0, audio_item.sample_in};
  assign rms_inv  = rmsng_pkg::POLE_ONE - {1'b0, regs.rms_coeff};
  assign pole_inv = rmsng_pkg::POLE_ONE - {1'b0, pole};
  assign pole_sum = acc + rmsng_pkg::POLE_HALF;
  assign out_sum  = acc + rmsng_pkg::OUT_HALF;

  assign gain_raw  = pole_sum[24 +: rmsng_pkg::GainW];
  assign gain_next = (gain_raw > rmsng_pkg::GAIN_ONE) ? rmsng_pkg::GAIN_ONE : gain_raw;

  assign above = mean_square > {1'b0, regs.threshold_power, 8'b0};
  always_comb begin
    priority if (above) begin
      hold_next = regs.hold_length;
    end else if (hold_count != '0) begin
      hold_next = hold_count - rmsng_pkg::HoldW'(1);
    end else begin
      hold_next = hold_count;
    end
  end

  assign floor_gain  = (regs.range_gain > rmsng_pkg::RANGE_MAX) ? rmsng_pkg::RANGE_MAX
                                                                 : regs.range_gain;
  assign target_next = gate_open ? rmsng_pkg::TGT_ONE : {floor_gain, 15'b0};

  // Rounded magnitude, never above the input magnitude.
  assign omag     = (out_sum[63:30] > 34'(mag)) ? mag : out_sum[30 +: rmsng_pkg::MagW];
  assign omag_neg = rmsng_pkg::MagW'(0) - omag;
  assign out_load = (state == S_OR) && (!gated_valid || !gated_stall);

  always_comb begin
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    unique case (state)
      S_SQ: begin
        mac_op = '{valid: 1'b1, clear: 1'b1, shift: 1'b0};
        mac_a  = rmsng_pkg::PoleW'(mag);
        mac_b  = rmsng_pkg::MulBW'(mag);
      end
      S_MS0: begin
        mac_op = '{valid: 1'b1, clear: 1'b1, shift: 1'b0};
        mac_a  = {1'b0, regs.rms_coeff};
        mac_b  = mean_square[19:0];
      end
      S_MS1: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b1};
        mac_a  = {1'b0, regs.rms_coeff};
        mac_b  = mean_square[39:20];
      end
      S_MS2: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b0};
        mac_a  = rms_inv;
        mac_b  = sq[19:0];
      end
      S_MS3: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b1};
        mac_a  = rms_inv;
        mac_b  = {1'b0, sq[38:20]};
      end
      S_G0: begin
        mac_op = '{valid: 1'b1, clear: 1'b1, shift: 1'b0};
        mac_a  = {1'b0, pole};
        mac_b  = gate_gain[19:0];
      end
      S_G1: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b1};
        mac_a  = {1'b0, pole};
        mac_b  = {8'b0, gate_gain[31:20]};
      end
      S_G2: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b0};
        mac_a  = pole_inv;
        mac_b  = target[19:0];
      end
      S_G3: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b1};
        mac_a  = pole_inv;
        mac_b  = {9'b0, target[30:20]};
      end
      S_O0: begin
        mac_op = '{valid: 1'b1, clear: 1'b1, shift: 1'b0};
        mac_a  = {5'b0, gate_gain[19:0]};
        mac_b  = {3'b0, mag};
      end
      S_O1: begin
        mac_op = '{valid: 1'b1, clear: 1'b0, shift: 1'b1};
        mac_a  = {13'b0, gate_gain[31:20]};
        mac_b  = {3'b0, mag};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mean_square <= '0;
      gate_gain   <= '0;
      hold_count  <= '0;
      gated_valid <= 1'b0;
    end else begin
      if (out_load) begin
        gated_valid <= 1'b1;
        gated_item.sample_out    <= neg ? omag_neg[15:0] : omag[15:0];
        gated_item.block_end_out <= blk;
      end else if (!gated_stall) begin
        gated_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (audio_valid) begin
            mag   <= mag_in;
            neg   <= audio_item.sample_in[rmsng_pkg::SampleW-1];
            blk   <= audio_item.block_end;
            state <= S_SQ;
          end
        end
        S_SQ:  state <= S_MS0;
        S_MS0: state <= S_MS1;
        S_MS1: begin
          sq    <= {acc[30:0], 8'b0};
          state <= S_MS2;
        end
        S_MS2: state <= S_MS3;
        S_MS3: state <= S_MSW;
        S_MSW: state <= S_MSR;
        S_MSR: begin
          mean_square <= pole_sum[24 +: rmsng_pkg::MsW];
          state       <= S_THR;
        end
        S_THR: begin
          hold_count <= hold_next;
          gate_open  <= above || (hold_next != '0);
          state      <= S_TGT;
        end
        S_TGT: begin
          target <= target_next;
          pole   <= ({1'b0, target_next} > gate_gain) ? regs.attack_coeff
                                                      : regs.release_coeff;
          state  <= S_G0;
        end
        S_G0: state <= S_G1;
        S_G1: state <= S_G2;
        S_G2: state <= S_G3;
        S_G3: state <= S_GW;
        S_GW: state <= S_GR;
        S_GR: begin
          gate_gain <= gain_next;
          state     <= S_O0;
        end
        S_O0: state <= S_O1;
        S_O1: state <= S_OW;
        S_OW: state <= S_OR;
        S_OR: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/rmsng_checker.sv */
// Port-level checks for the RMS noise gate, bound to the top level.
// Depends on rmsng_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmsng_checker (
  input logic clk,
  input logic rst,
  input logic audio_valid,
  input logic audio_stall,
  input logic gated_valid,
  input logic gated_stall,
  input rmsng_pkg::out_item_t gated_item,
  input logic cfg_valid,
  input logic cfg_ready
);

  `RMSNG_ASSERT(a_busy_after_accept, clk, rst,
    (audio_valid && !audio_stall) |=> audio_stall,
    "input not stalled after item accepted")
  `RMSNG_ASSERT(a_out_from_busy, clk, rst,
    $rose(gated_valid) |-> $past(audio_stall),
    "result appeared without an item in work")
  `RMSNG_ASSERT(a_out_hold, clk, rst,
    (gated_valid && gated_stall) |=> (gated_valid && $stable(gated_item)),
    "stalled result changed")
  `RMSNG_NEVER(a_cfg_ready, clk, rst, cfg_valid && !cfg_ready, "config write refused")

endmodule

bind rms_noise_gate_top rmsng_checker u_rmsng_checker (.*);

/* tb/tb_rms_noise_gate_top.sv */
// Testbench for rms_noise_gate_top: drives sample items and register writes,
// predicts each gated sample in the bench itself and checks every result in order.
// Depends on rmsng_pkg and the rms_noise_gate_top RTL.
module tb_rms_noise_gate_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rmsng_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rmsng_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 24;

  logic clk;
  logic rst;
  logic audio_valid;
  logic audio_stall;
  rmsng_pkg::in_item_t audio_item;
  logic gated_valid;
  logic gated_stall = 1'b0;
  rmsng_pkg::out_item_t gated_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [rmsng_pkg::CfgIdxW-1:0] cfg_index;
  logic [rmsng_pkg::CfgDatW-1:0] cfg_data;

  rms_noise_gate_top dut (
    .clk         (clk),
    .rst         (rst),
    .audio_valid (audio_valid),
    .audio_stall (audio_stall),
    .audio_item  (audio_item),
    .gated_valid (gated_valid),
    .gated_stall (gated_stall),
    .gated_item  (gated_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // gate model state
  rmsng_pkg::cfg_t shadow_cfg = rmsng_pkg::CFG_RESET;
  logic [63:0] env_ms = '0;
  logic [63:0] gate_gain_q30 = '0;
  logic [15:0] hold_left = '0;

  rmsng_pkg::out_item_t gated_expect_q[$];
  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_off_left = 0;

  // burst generator state
  int burst_left = 0;
  int burst_amp = 0;
  bit burst_noise = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] pole_mix(logic [63:0] c, logic [63:0] x, logic [63:0] t);
    return (c * x + ((64'd1 << 24) - c) * t + (64'd1 << 23)) >> 24;
  endfunction

  function automatic rmsng_pkg::out_item_t gate_predict(rmsng_pkg::in_item_t it);
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] tgt;
    logic [63:0] pole;
    logic [63:0] omag;
    logic [15:0] flr;
    logic above;
    logic is_open;
    rmsng_pkg::out_item_t r;
    mag = it.sample_in[15] ? (64'h10000 - 64'({1'b0, it.sample_in}))
                           : 64'({1'b0, it.sample_in});
    sq = (mag * mag) << 8;
    env_ms = pole_mix(64'(shadow_cfg.rms_coeff), env_ms, sq);
    above = env_ms > (64'(shadow_cfg.threshold_power) << 8);
    if (above) begin
      hold_left = shadow_cfg.hold_length;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 16'd1;
    end
    is_open = above || (hold_left != 0);
    flr = (shadow_cfg.range_gain > 16'd32768) ? 16'd32768 : shadow_cfg.range_gain;
    tgt = is_open ? (64'd1 << 30) : (64'(flr) << 15);
    pole = (tgt > gate_gain_q30) ? 64'(shadow_cfg.attack_coeff)
                                 : 64'(shadow_cfg.release_coeff);
    gate_gain_q30 = pole_mix(pole, gate_gain_q30, tgt);
    if (gate_gain_q30 > (64'd1 << 30)) begin
      gate_gain_q30 = 64'd1 << 30;
    end
    omag = (mag * gate_gain_q30 + (64'd1 << 29)) >> 30;
    if (omag > mag) begin
      omag = mag;
    end
    r.sample_out = it.sample_in[15] ? 16'(64'h10000 - omag) : 16'(omag);
    r.block_end_out = it.block_end;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    end
  endtask

  // results, item predictions and register shadow, all sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && gated_valid && !gated_stall) begin
      if (gated_expect_q.size() == 0) begin
        report_mismatch("unexpected item", $signed(gated_item.sample_out), 0);
      end else begin
        if (gated_item.sample_out !== gated_expect_q[0].sample_out) begin
          report_mismatch("sample_out", $signed(gated_item.sample_out),
                          $signed(gated_expect_q[0].sample_out));
        end
        if (gated_item.block_end_out !== gated_expect_q[0].block_end_out) begin
          report_mismatch("block_end_out", gated_item.block_end_out,
                          gated_expect_q[0].block_end_out);
        end
        void'(gated_expect_q.pop_front());
      end
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmsng_pkg::REG_THRESHOLD:
          shadow_cfg.threshold_power = cfg_data[rmsng_pkg::ThrW-1:0];
        rmsng_pkg::REG_RANGE:
          shadow_cfg.range_gain = cfg_data[rmsng_pkg::RangeW-1:0];
        rmsng_pkg::REG_ATTACK:
          shadow_cfg.attack_coeff = cfg_data[rmsng_pkg::CoeffW-1:0];
        rmsng_pkg::REG_RELEASE:
          shadow_cfg.release_coeff = cfg_data[rmsng_pkg::CoeffW-1:0];
        rmsng_pkg::REG_RMS:
          shadow_cfg.rms_coeff = cfg_data[rmsng_pkg::CoeffW-1:0];
        rmsng_pkg::REG_HOLD:
          shadow_cfg.hold_length = cfg_data[rmsng_pkg::HoldW-1:0];
        default: ;
      endcase
    end
    if (!rst && audio_valid && !audio_stall) begin
      gated_expect_q.push_back(gate_predict(audio_item));
    end
  end

  always @(posedge clk) begin
    if (rst || (audio_valid && !audio_stall) || (gated_valid && !gated_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // output back-pressure: long hold-off first, random stall otherwise
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      gated_stall <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else begin
      gated_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_sample(rmsng_pkg::in_item_t it);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 30) : 0;
    @(negedge clk);
    if (gap != 0) begin
      audio_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    audio_valid = 1'b1;
    audio_item = it;
    @(posedge clk);
    while (audio_stall) @(posedge clk);
  endtask

  task automatic send_value(int value, bit last);
    rmsng_pkg::in_item_t it;
    it.sample_in = 16'(value);
    it.block_end = last;
    send_sample(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    audio_valid = 1'b0;
    while (gated_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [rmsng_pkg::CfgIdxW-1:0] idx,
                           logic [rmsng_pkg::CfgDatW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [30:0] thr, logic [15:0] rng, logic [23:0] att,
                           logic [23:0] rel, logic [23:0] rms, logic [15:0] hold);
    write_reg(rmsng_pkg::REG_THRESHOLD, thr);
    write_reg(rmsng_pkg::REG_RANGE, 31'(rng));
    write_reg(rmsng_pkg::REG_ATTACK, 31'(att));
    write_reg(rmsng_pkg::REG_RELEASE, 31'(rel));
    write_reg(rmsng_pkg::REG_RMS, 31'(rms));
    write_reg(rmsng_pkg::REG_HOLD, 31'(hold));
  endtask

  function automatic logic [23:0] pick_pole();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2, 3: return 24'($urandom);
      default: return 24'hFFFFFF - 24'($urandom_range(0, 1 << $urandom_range(4, 20)));
    endcase
  endfunction

  // unused high data bits are sometimes set; the block keeps only the field width
  function automatic logic [30:0] with_junk(logic [30:0] value, int width);
    logic [30:0] junk;
    junk = 31'($urandom) & ~((31'd1 << width) - 31'd1);
    return ($urandom_range(3) == 0) ? (value | junk) : value;
  endfunction

  task automatic set_random_config();
    logic [30:0] thr;
    logic [15:0] rng;
    logic [15:0] hold;
    case ($urandom_range(7))
      0: thr = 31'd0;
      1: thr = 31'd1 << 30;
      2: thr = 31'h7FFFFFFF;
      default: thr = 31'($urandom_range(0, 1 << $urandom_range(0, 30)));
    endcase
    case ($urandom_range(5))
      0: rng = 16'd0;
      1: rng = 16'd32768;
      2: rng = 16'($urandom_range(32769, 65535));
      default: rng = 16'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(5))
      0: hold = 16'd0;
      1: hold = 16'hFFFF;
      default: hold = 16'($urandom_range(1, 64));
    endcase
    write_reg(rmsng_pkg::REG_THRESHOLD, thr);
    write_reg(rmsng_pkg::REG_RANGE, with_junk(31'(rng), rmsng_pkg::RangeW));
    write_reg(rmsng_pkg::REG_ATTACK, with_junk(31'(pick_pole()), rmsng_pkg::CoeffW));
    write_reg(rmsng_pkg::REG_RELEASE, with_junk(31'(pick_pole()), rmsng_pkg::CoeffW));
    write_reg(rmsng_pkg::REG_RMS, with_junk(31'(pick_pole()), rmsng_pkg::CoeffW));
    write_reg(rmsng_pkg::REG_HOLD, with_junk(31'(hold), rmsng_pkg::HoldW));
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 31'($urandom));
    end
  endtask

  // bursts of loud, quiet or full-range noise so the gate opens and closes
  function automatic rmsng_pkg::in_item_t next_sample();
    rmsng_pkg::in_item_t it;
    int v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      burst_noise = ($urandom_range(4) == 0);
      case ($urandom_range(2))
        0: burst_amp = $urandom_range(0, 255);
        1: burst_amp = $urandom_range(256, 8191);
        default: burst_amp = $urandom_range(8192, 32767);
      endcase
    end
    burst_left--;
    if (burst_noise) begin
      it.sample_in = 16'($urandom);
    end else if ($urandom_range(63) == 0) begin
      it.sample_in = 16'sh8000;
    end else begin
      v = $urandom_range(0, 2 * burst_amp) - burst_amp;
      it.sample_in = 16'(v);
    end
    it.block_end = ($urandom_range(7) == 0);
    return it;
  endfunction

  task automatic test_reset_defaults();
    send_value(0, 1'b0);
    send_value(32767, 1'b0);
    send_value(-32768, 1'b1);
    send_value(1, 1'b0);
    send_value(-1, 1'b0);
    send_value(0, 1'b1);
    wait_idle();
  endtask

  // instant poles: range above unity, then a zero floor with the gate shut only on silence
  task automatic test_fast_poles();
    write_all(31'd0, 16'hFFFF, 24'd0, 24'd0, 24'd0, 16'd0);
    send_value(32767, 1'b0);
    send_value(-32768, 1'b1);
    send_value(0, 1'b0);
    wait_idle();
    write_reg(rmsng_pkg::REG_RANGE, 31'd0);
    send_value(-32768, 1'b0);
    send_value(100, 1'b0);
    send_value(0, 1'b0);
    send_value(-5, 1'b1);
    wait_idle();
  endtask

  // threshold above full scale keeps the gate shut; then hold counts down
  task automatic test_threshold_and_hold();
    write_all(31'h7FFFFFFF, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 16'hFFFF);
    send_value(32767, 1'b0);
    send_value(-32768, 1'b0);
    wait_idle();
    write_all(31'd0, 16'd16384, 24'd0, 24'd0, 24'd0, 16'd3);
    send_value(-32768, 1'b0);
    repeat (4) send_value(0, 1'b0);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_LO, 31'h7FFFFFFF);
    write_reg(REG_SPARE_HI, 31'd0);
    send_value(12345, 1'b0);
    send_value(-12345, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int s = 0; s < 5; s++) begin
      set_random_config();
      for (int i = 0; i < n_items / 5; i++) begin
        send_sample(next_sample());
      end
      wait_idle();
    end
  endtask

  // output held off while the sender keeps pushing, so the input backs up
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    set_random_config();
    @(posedge clk);
    hold_off_left = 150;
    for (int i = 0; i < 16; i++) begin
      send_sample(next_sample());
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    audio_valid = 1'b0;
    audio_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_fast_poles();
    test_threshold_and_hold();
    test_spare_index();
    test_random_traffic(0, 0, 250);
    test_random_traffic(80, 0, 250);
    test_random_traffic(0, 80, 250);
    test_random_traffic(34, 34, 250);
    test_output_backpressure();

    @(negedge clk);
    audio_valid = 1'b0;
    while (gated_expect_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rmsng_pkg.sv
sv/rmsng_cfg.sv
sv/rmsng_mac.sv
sv/rmsng_ctrl.sv
sv/rms_noise_gate_top.sv
sv/rmsng_checker.sv
tb/tb_rms_noise_gate_top.sv
